### rtl/drpm_pkg.sv
package drpm_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_RANGE_MIN  = 2'd0;
    localparam logic [1:0] CFG_RANGE_MAX  = 2'd1;
    localparam logic [1:0] CFG_DEPTH_COLS = 2'd2;
    localparam logic [1:0] CFG_DEPTH_ROWS = 2'd3;

    // Reset values of the configuration registers
    localparam logic [15:0] RANGE_MIN_RST  = 16'd700;
    localparam logic [15:0] RANGE_MAX_RST  = 16'd900;
    localparam logic [9:0]  DEPTH_COLS_RST = 10'd512;
    localparam logic [9:0]  DEPTH_ROWS_RST = 10'd424;

    // Item operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    typedef struct packed {
        logic               op;
        logic [17:0]        load_addr;
        logic [15:0]        load_depth;
        logic               map_ok;
        logic signed [15:0] map_col;
        logic signed [15:0] map_row;
        logic [7:0]         red_in;
        logic [7:0]         green_in;
        logic [7:0]         blue_in;
        logic               frame_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       kept;
        logic       frame_end_out;
    } t_out_item;

endpackage

### rtl/drpm_in_if.sv
interface drpm_in_if
    import drpm_pkg::*;
;
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/drpm_out_if.sv
interface drpm_out_if
    import drpm_pkg::*;
;
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/drpm_cfg_if.sv
interface drpm_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/drpm_ram.sv
module drpm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single port: write, or read into the output register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/depth_range_pixel_mask.sv
// Channel | Port  | Dir | Moves
// --------+-------+-----+------------------------------------------------
// input   | i_in  | in  | load item (depth sample) or color pixel item
// output  | o_out | out | one masked pixel per color pixel item
// config  | i_cfg | in  | register writes: range min/max, frame cols/rows
//
// One item enters per cycle unless the pipeline holds; a pixel's result passes
// each stage. The depth store is a single-port memory with registered read,
// and a load and a pixel share its one port by taking turns in stage order.
// The whole pipeline holds while the output register is full and not taken.
// Reset (synchronous, active low) clears valid bits and loads the configuration
// reset values; the depth store is not cleared and needs no clearing pass.
module depth_range_pixel_mask
    import drpm_pkg::*;
#(
    parameter int DEPTH_WORDS     = 262144,
    parameter int COORD_FRAC_BITS = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    drpm_in_if.sink    i_in,
    drpm_out_if.source o_out,
    drpm_cfg_if.sink   i_cfg
);
    localparam int AW = $clog2(DEPTH_WORDS);
    // Computed address: column (10 bits) plus row * cols (20 bits)
    localparam int PW = 21;
    // 2 * coordinate needs 17 bits, adding the half needs one more
    localparam int SW = 18;
    localparam logic [PW-1:0]        DW_P    = PW'(DEPTH_WORDS);
    localparam logic signed [SW-1:0] HALF    = SW'(1 << COORD_FRAC_BITS);
    localparam logic signed [SW-1:0] NEG_LIM = SW'(-(2 ** (COORD_FRAC_BITS + 1)));

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
        logic       is_pix;
    } t_side;

    // Round by adding one half and truncating toward zero: {ok, index}
    function automatic logic [16:0] round_idx(input logic signed [15:0] v);
        logic signed [SW-1:0] s;
        logic signed [SW-1:0] sh;
        logic                 ok;
        s  = $signed({{(SW-17){v[15]}}, v, 1'b0}) + HALF;
        sh = s >>> (COORD_FRAC_BITS + 1);
        ok = !s[SW-1] || (s > NEG_LIM);
        return {ok, s[SW-1] ? 16'd0 : sh[15:0]};
    endfunction

    logic [15:0] r_range_min;
    logic [15:0] r_range_max;
    logic [9:0]  r_depth_cols;
    logic [9:0]  r_depth_rows;

    // Configuration writes are always taken
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_min  <= RANGE_MIN_RST;
            r_range_max  <= RANGE_MAX_RST;
            r_depth_cols <= DEPTH_COLS_RST;
            r_depth_rows <= DEPTH_ROWS_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_RANGE_MIN:  r_range_min  <= i_cfg.data;
                CFG_RANGE_MAX:  r_range_max  <= i_cfg.data;
                CFG_DEPTH_COLS: r_depth_cols <= i_cfg.data[9:0];
                CFG_DEPTH_ROWS: r_depth_rows <= i_cfg.data[9:0];
                default: ;
            endcase
        end
    end

    // Pipeline registers
    logic        r1_v, r2_v, r3_v, r4_v, r_out_v;
    t_side       r1_side, r2_side, r3_side, r4_side;
    logic        r1_map_ok, r1_col_ok, r1_row_ok;
    logic [15:0] r1_col, r1_row;
    logic [17:0] r1_load_addr;
    logic [15:0] r1_load_depth, r2_load_depth, r3_load_depth;
    logic        r2_ok;
    logic [PW-1:0] r2_base, r2_prod;
    logic        r3_ok;
    logic [AW-1:0] r3_addr;
    logic        r4_ok;
    t_out_item   r_out;

    logic        w_adv;
    logic [16:0] w_col_rnd, w_row_rnd;
    t_side       w_side;
    logic        w_in_range;
    logic [19:0] w_prod;
    logic [PW-1:0] w_sum;
    logic [15:0] w_depth;
    logic        w_keep;
    logic        w_ram_en, w_ram_we;

    // Advance everything unless a finished result waits
    assign w_adv      = !r_out_v || o_out.ready;
    assign i_in.ready = w_adv;

    assign w_col_rnd = round_idx(i_in.data.map_col);
    assign w_row_rnd = round_idx(i_in.data.map_row);
    assign w_side    = '{red: i_in.data.red_in, green: i_in.data.green_in,
                         blue: i_in.data.blue_in, frame_end: i_in.data.frame_end,
                         is_pix: i_in.data.op == OP_PIXEL};

    // Stage 2 logic: bounds check and row * cols
    assign w_in_range = r1_map_ok && r1_col_ok && r1_row_ok
                        && (r1_col < {6'd0, r_depth_cols})
                        && (r1_row < {6'd0, r_depth_rows});
    assign w_prod     = r1_row[9:0] * r_depth_cols;

    // Stage 3 logic: final address
    assign w_sum = r2_base + r2_prod;

    // Store access from stage 3; read data lands beside stage 4
    assign w_ram_en = w_adv && r3_v;
    assign w_ram_we = !r3_side.is_pix && r3_ok;

    drpm_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH_WORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (w_ram_en),
        .i_we    (w_ram_we),
        .i_addr  (r3_addr),
        .i_wdata (r3_load_depth),
        .o_rdata (w_depth)
    );

    // Stage 4 logic: range test
    assign w_keep = r4_ok && (w_depth > r_range_min) && (w_depth < r_range_max);

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r4_v    <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r1_v    <= i_in.valid;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            r4_v    <= r3_v;
            r_out_v <= r4_v && r4_side.is_pix;
        end
    end

    // Payload, held on stall
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_side       <= w_side;
            r1_map_ok     <= i_in.data.map_ok;
            r1_col_ok     <= w_col_rnd[16];
            r1_col        <= w_col_rnd[15:0];
            r1_row_ok     <= w_row_rnd[16];
            r1_row        <= w_row_rnd[15:0];
            r1_load_addr  <= i_in.data.load_addr;
            r1_load_depth <= i_in.data.load_depth;

            r2_side       <= r1_side;
            r2_load_depth <= r1_load_depth;
            if (r1_side.is_pix) begin
                r2_ok   <= w_in_range;
                r2_base <= PW'(r1_col[9:0]);
                r2_prod <= PW'(w_prod);
            end else begin
                r2_ok   <= 1'b1;
                r2_base <= PW'(r1_load_addr);
                r2_prod <= '0;
            end

            r3_side       <= r2_side;
            r3_load_depth <= r2_load_depth;
            r3_ok         <= r2_ok && (w_sum < DW_P);
            r3_addr       <= w_sum[AW-1:0];

            r4_side <= r3_side;
            r4_ok   <= r3_ok;

            r_out.red_out       <= w_keep ? r4_side.red : 8'd0;
            r_out.green_out     <= w_keep ? r4_side.green : 8'd0;
            r_out.blue_out      <= w_keep ? r4_side.blue : 8'd0;
            r_out.kept          <= w_keep;
            r_out.frame_end_out <= r4_side.frame_end;
        end
    end

    assign o_out.valid = r_out_v;
    assign o_out.data  = r_out;

    // A waiting result stops intake
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && !o_out.ready |-> !i_in.ready)
        else $error("input taken while result stalled");

    // A masked result is black
    a_masked_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && !r_out.kept |->
            r_out.red_out == 8'd0 && r_out.green_out == 8'd0 && r_out.blue_out == 8'd0)
        else $error("masked pixel not black");

    // A pixel in the last stage becomes a result on advance
    a_pixel_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r4_v && r4_side.is_pix |=> r_out_v)
        else $error("pixel result lost");

    // A load never becomes a result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r4_v && !r4_side.is_pix |=> !r_out_v)
        else $error("load item produced a result");
endmodule
